@@ src/hmtp_pkg.sv @@
// Shared types and constants for the height map text parser.
`default_nettype none

package hmtp_pkg;

    // Character codes of the map text
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] HEX_UPPER_OFS = 8'd55;
    localparam logic [7:0] HEX_LOWER_OFS = 8'd87;
    localparam logic [7:0] CHAN_FULL     = 8'd255;

    // Grid geometry; row and column counters wrap at their natural width
    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int COLS_W   = 13;
    localparam int HEIGHT_W = 32;
    localparam int MAX_COLS = 1 << COL_W;
    localparam int HEX_W    = 48;
    localparam int HCNT_W   = 3;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_IDLE_NL = 7'b0000010,
        PH_FIRST   = 7'b0000100,
        PH_DIGITS  = 7'b0001000,
        PH_SKIP1   = 7'b0010000,
        PH_SKIP2   = 7'b0100000,
        PH_HEX     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [HEIGHT_W-1:0] height;
        color_t              color;
        logic                row_end;
    } result_t;

endpackage

`default_nettype wire

@@ src/hmtp_color.sv @@
// Colour decode: turns the last hex bytes of a cell into red, green and blue.
`default_nettype none

module hmtp_color
    import hmtp_pkg::*;
(
    input  wire logic [HEX_W-1:0]  hex_values,
    input  wire logic [HCNT_W-1:0] hex_count,
    output color_t                 color
);

    // Hex value of a byte; anything else keeps its raw code
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= 8'd57) begin
            v = c - CH_ZERO;
        end else if (c >= 8'd65 && c <= 8'd70) begin
            v = c - HEX_UPPER_OFS;
        end else if (c >= 8'd97 && c <= 8'd102) begin
            v = c - HEX_LOWER_OFS;
        end else begin
            v = c;
        end
        return v;
    endfunction

    // (hi * 16 + lo) mod 256
    function automatic logic [7:0] channel(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        h = hex_digit(hi);
        return {h[3:0], 4'b0000} + hex_digit(lo);
    endfunction

    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;

    assign ch0 = channel(hex_values[15:8],  hex_values[7:0]);
    assign ch1 = channel(hex_values[31:24], hex_values[23:16]);
    assign ch2 = channel(hex_values[47:40], hex_values[39:32]);

    always_comb begin
        color = '0;
        case (hex_count)
            3'd2: begin
                color.blue = ch0;
            end
            3'd4: begin
                color.blue  = ch0;
                color.green = ch1;
            end
            3'd6: begin
                color.blue  = ch0;
                color.green = ch1;
                color.red   = ch2;
            end
            default: begin
                color = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/hmtp_core.sv @@
// Parser state machine, height accumulator, colour shifter and grid counters.
`default_nettype none

module hmtp_core
    import hmtp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        ch,
    input  wire logic [COLS_W-1:0] columns,
    output logic                   emit,
    output result_t                result
);

    phase_t               phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [HEIGHT_W-1:0]  acc_reg, acc_next;
    logic [HEX_W-1:0]     hex_reg, hex_next;
    logic [HCNT_W-1:0]    cnt_reg, cnt_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;

    logic                 start;
    logic                 has_color;
    logic                 is_sep;
    logic [HEIGHT_W-1:0]  digit;
    logic [COLS_W-1:0]    last_wide;
    logic [COL_W-1:0]     last_col;
    color_t               hex_color;

    // Effective last column: 0 acts as 1, oversize clamps to MAX_COLS
    always_comb begin
        if (columns == '0) begin
            last_wide = '0;
        end else if (columns > COLS_W'(MAX_COLS)) begin
            last_wide = COLS_W'(MAX_COLS - 1);
        end else begin
            last_wide = columns - COLS_W'(1);
        end
    end
    assign last_col = last_wide[COL_W-1:0];

    assign is_sep = (ch == CH_SPACE) || (ch == CH_NL);
    assign digit  = {{(HEIGHT_W-8){1'b0}}, ch} - {{(HEIGHT_W-8){1'b0}}, CH_ZERO};

    hmtp_color u_color (
        .hex_values (hex_reg),
        .hex_count  (cnt_reg),
        .color      (hex_color)
    );

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        hex_next   = hex_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        start      = 1'b0;
        emit       = 1'b0;
        has_color  = 1'b0;
        if (step) begin
            unique case (phase_reg)
                PH_IDLE_NL: begin
                    if (ch == CH_NL) begin
                        phase_next = PH_IDLE;
                    end else if (ch != CH_SPACE) begin
                        start = 1'b1;
                    end
                end
                PH_IDLE: begin
                    start = (ch != CH_SPACE);
                end
                PH_FIRST: begin
                    acc_next   = digit;
                    phase_next = PH_DIGITS;
                end
                PH_DIGITS: begin
                    if (ch == CH_COMMA) begin
                        phase_next = PH_SKIP1;
                    end else if (is_sep) begin
                        emit = 1'b1;
                    end else begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + digit;
                    end
                end
                PH_SKIP1: begin
                    phase_next = PH_SKIP2;
                end
                PH_SKIP2: begin
                    phase_next = PH_HEX;
                end
                PH_HEX: begin
                    if (is_sep) begin
                        emit      = 1'b1;
                        has_color = 1'b1;
                    end else begin
                        hex_next = {hex_reg[HEX_W-9:0], ch};
                        if (cnt_reg != '1) begin
                            cnt_next = cnt_reg + HCNT_W'(1);
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (start) begin
                if (ch == CH_MINUS) begin
                    neg_next   = 1'b1;
                    phase_next = PH_FIRST;
                end else begin
                    acc_next   = digit;
                    phase_next = PH_DIGITS;
                end
            end

            if (emit) begin
                if (col_reg < last_col) begin
                    col_next = col_reg + COL_W'(1);
                end else begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                neg_next   = 1'b0;
                acc_next   = '0;
                hex_next   = '0;
                cnt_next   = '0;
                phase_next = (ch == CH_SPACE) ? PH_IDLE_NL : PH_IDLE;
            end
        end
    end

    always_comb begin
        result.col     = col_reg;
        result.row     = row_reg;
        result.height  = neg_reg ? (~acc_reg + HEIGHT_W'(1)) : acc_reg;
        result.color   = has_color ? hex_color : '{CHAN_FULL, CHAN_FULL, CHAN_FULL};
        result.row_end = (col_reg == last_col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            hex_reg   <= '0;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            hex_reg   <= hex_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ src/height_map_text_parser.sv @@
// Top level of the height map text parser: input beat register, parser core, result register.
// A byte held in the input register steps the core once the result slot is free or draining.
// Throughput: one byte per cycle while m_tready stays high; the input register and
//   the result register let a new byte in while a finished cell waits downstream.
// Reset (aresetn low, synchronous): parser idle between cells, counters at row 0
//   column 0, columns register at 1, both beat registers empty.
`default_nettype none

module height_map_text_parser
    import hmtp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    // Input stream: tdata = ch[7:0]
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,

    // Result stream: tdata = col[11:0], row[23:12], height[55:24],
    //   red[63:56], green[71:64], blue[79:72]; tlast = row_end
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [79:0]            m_tdata,
    output logic                   m_tlast,

    // Configuration: columns[12:0]
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [COLS_W-1:0] cfg_data
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg,  in_byte_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [COLS_W-1:0] columns_reg, columns_next;

    logic    advance;
    logic    emit;
    result_t result;

    // The core steps whenever a byte is held and the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            // old result (if any) is taken this cycle
            out_valid_next = emit;
            if (emit) begin
                out_next = result;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign columns_next = (cfg_valid && cfg_ready) ? cfg_data : columns_reg;

    hmtp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .ch      (in_byte_reg),
        .columns (columns_reg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            columns_reg   <= COLS_W'(1);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            columns_reg   <= columns_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.color.blue, out_reg.color.green, out_reg.color.red,
                       out_reg.height, out_reg.row, out_reg.col};
    assign m_tlast  = out_reg.row_end;

    // Backpressure only when both beat registers are full and downstream stalls.
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready low without a full, stalled pipeline");

    // A cell ending in the core lands in the result register on the next edge.
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |=> out_valid_reg)
        else $error("emitted cell lost");

    // A held byte that cannot step stays put.
    a_hold_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte changed");

endmodule

`default_nettype wire
